[rtl/knn_inverse_distance_interpolator_unit_defines.svh]
// Assertion macros shared by the front, divider and back-end RTL files.
`ifndef KNN_INVERSE_DISTANCE_INTERPOLATOR_UNIT_DEFINES_SVH
`define KNN_INVERSE_DISTANCE_INTERPOLATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define KNN_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define KNN_ASSERT(lbl, prop, msg) \
    `KNN_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)
`else
`define KNN_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define KNN_ASSERT(lbl, prop, msg)
`endif

`endif

[rtl/knn_idw_pkg.sv]
`default_nettype none

package knn_idw_pkg;

    localparam int TABLE_DEPTH   = 4096;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
    localparam int MAX_NEIGHBORS = 16;
    localparam int NB_IDX_W      = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int NB_CNT_W      = $clog2(MAX_NEIGHBORS + 1);

    localparam int COORD_W     = 24;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SQ_W        = 2 * COORD_W + 2;
    localparam int FRAC_W      = 16;
    localparam int RAD_W       = SQ_W + FRAC_W;
    localparam int DIST_W      = RAD_W / 2;
    localparam int SQRT_STAGES = DIST_W;
    localparam int REM_W       = DIST_W + 3;
    localparam int RADIUS_W    = 26;
    localparam int LIMIT_W     = 5;

    localparam int DIV_W     = 64;
    localparam int DEN_W     = 37;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int W_W       = 33;
    localparam int PROD_W    = W_W + 1 + COORD_W;
    localparam int SWZ_W     = 61;
    localparam logic [DIV_W-1:0] WEIGHT_NUM = DIV_W'(1) << 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_ADDR_W = 3;
    localparam logic REG_RADIUS = 1'b0;
    localparam logic REG_LIMIT  = 1'b1;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] height;
    } t_in_item;

    typedef struct packed {
        logic                      found;
        logic signed [COORD_W-1:0] height_out;
        logic                      table_full;
    } t_out_item;

    typedef struct packed {
        logic [1:0]                code;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] height;
    } t_cmd;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } t_div_rsp;

endpackage

`default_nettype wire

[rtl/knn_idw_front.sv]
`default_nettype none
`include "knn_inverse_distance_interpolator_unit_defines.svh"

module knn_idw_front import knn_idw_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_cmd_valid,
    output t_cmd          o_cmd,
    input  wire logic     i_cmd_pop
);

    t_cmd               r_q [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               push;
    logic               pop;
    t_cmd               cmd;

    always_comb begin
        cmd.pos_x  = i_in_item.pos_x;
        cmd.pos_y  = i_in_item.pos_y;
        cmd.height = i_in_item.height;
        case (i_in_item.func)
            FUNC_LOAD:  cmd.code = CMD_LOAD;
            FUNC_QUERY: cmd.code = CMD_QUERY;
            FUNC_CLEAR: cmd.code = CMD_CLEAR;
            default:    cmd.code = CMD_NOP;
        endcase
    end

    assign o_in_stall  = (r_cnt == Q_CNT_W'(QUEUE_DEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

    `KNN_ASSERT(a_queue_ptrs, (Q_PTR_W'(r_wr_ptr - r_rd_ptr) == r_cnt[Q_PTR_W-1:0]), "queue count and pointers disagree")

endmodule

`default_nettype wire

[rtl/knn_idw_div.sv]
`default_nettype none
`include "knn_inverse_distance_interpolator_unit_defines.svh"

module knn_idw_div import knn_idw_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W:0]       r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DEN_W:0]       rem_s;
    logic                 ge;
    logic [DEN_W:0]       rem_n;

    always_comb begin
        rem_s = {r_rem[DEN_W-1:0], r_num[DIV_W-1]};
        ge    = (rem_s >= {1'b0, r_den});
        rem_n = ge ? (rem_s - {1'b0, r_den}) : rem_s;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], 1'b0};
            r_rem <= rem_n;
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    `KNN_ASSERT(a_div_no_restart, (i_req.start |-> !r_busy), "divider started while busy")

endmodule

`default_nettype wire

[rtl/knn_idw_back.sv]
`default_nettype none
`include "knn_inverse_distance_interpolator_unit_defines.svh"

module knn_idw_back import knn_idw_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cmd_valid,
    input  wire t_cmd                i_cmd,
    output logic                     o_cmd_pop,
    input  wire logic [RADIUS_W-1:0] i_radius,
    input  wire logic [LIMIT_W-1:0]  i_limit,
    output t_div_req                 o_div_req,
    input  wire t_div_rsp            i_div_rsp,
    output logic                     o_out_valid,
    output t_out_item                o_out_item,
    input  wire logic                i_out_stall
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_WDIV  = 4'd2;
    localparam logic [3:0] ST_WWAIT = 4'd3;
    localparam logic [3:0] ST_WMUL  = 4'd4;
    localparam logic [3:0] ST_WACC  = 4'd5;
    localparam logic [3:0] ST_FDIV  = 4'd6;
    localparam logic [3:0] ST_FWAIT = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0]    r_state,    n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_scan_idx, n_scan_idx;
    logic [NB_CNT_W-1:0] r_nb_n, n_nb_n;
    logic [NB_CNT_W-1:0] r_wj,   n_wj;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out_item,  n_out_item;
    t_out_item     r_res,       n_res;
    logic signed [COORD_W-1:0] r_qx, n_qx;
    logic signed [COORD_W-1:0] r_qy, n_qy;
    logic [W_W-1:0] r_w, n_w;
    logic signed [COORD_W-1:0] r_cur_z, n_cur_z;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic signed [SWZ_W-1:0]   r_swz, n_swz;
    logic [DEN_W-1:0]          r_sw, n_sw;
    logic [DIST_W-1:0]         r_nb_d [MAX_NEIGHBORS];
    logic [DIST_W-1:0]         n_nb_d [MAX_NEIGHBORS];
    logic signed [COORD_W-1:0] r_nb_z [MAX_NEIGHBORS];
    logic signed [COORD_W-1:0] n_nb_z [MAX_NEIGHBORS];

    logic [3*COORD_W-1:0] r_mem [TABLE_DEPTH];
    logic [3*COORD_W-1:0] r_rd_data;
    logic                 r_rd_v, n_rd_v;
    logic                 mem_we;

    logic signed [DIFF_W-1:0]  r_dx, r_dy;
    logic signed [COORD_W-1:0] r_b_z;
    logic                      r_b_v;
    logic signed [2*DIFF_W-1:0] sqx, sqy;
    logic [SQ_W-2:0]            r_sx, r_sy;
    logic signed [COORD_W-1:0]  r_c_z;
    logic                       r_c_v;
    logic [SQ_W-1:0]            sq_sum;

    logic [REM_W-1:0]          r_sq_rem  [SQRT_STAGES+1];
    logic [DIST_W-1:0]         r_sq_root [SQRT_STAGES+1];
    logic [RAD_W-1:0]          r_sq_rad  [SQRT_STAGES+1];
    logic signed [COORD_W-1:0] r_sq_z    [SQRT_STAGES+1];
    logic [SQRT_STAGES:0]      r_sq_v;
    logic [REM_W-1:0]          n_sq_rem  [SQRT_STAGES+1];
    logic [DIST_W-1:0]         n_sq_root [SQRT_STAGES+1];
    logic [RAD_W-1:0]          n_sq_rad  [SQRT_STAGES+1];

    logic [NB_CNT_W-1:0]       k_eff;
    logic [MAX_NEIGHBORS-1:0]  le;
    logic [NB_CNT_W-1:0]       ins_p;
    logic [NB_CNT_W-1:0]       ins_n;
    logic                      nb_accept;
    logic [DIST_W-1:0]         ins_d [MAX_NEIGHBORS];
    logic signed [COORD_W-1:0] ins_z [MAX_NEIGHBORS];
    logic [DIST_W-1:0]         cand_d;
    logic                      pipe_busy;
    logic                      scan_issue;
    logic [NB_IDX_W-1:0]       wj_idx;
    logic [SWZ_W-1:0]          swz_mag;
    logic [COORD_W-1:0]        q_mag;

    assign k_eff = (i_limit == '0) ? NB_CNT_W'(1) :
                   (i_limit > LIMIT_W'(MAX_NEIGHBORS)) ? NB_CNT_W'(MAX_NEIGHBORS) :
                   NB_CNT_W'(i_limit);

    assign cand_d     = r_sq_root[SQRT_STAGES];
    assign pipe_busy  = r_rd_v || r_b_v || r_c_v || (|r_sq_v);
    assign scan_issue = (r_scan_idx != r_count);
    assign wj_idx     = r_wj[NB_IDX_W-1:0];
    assign swz_mag    = r_swz[SWZ_W-1] ? $unsigned(-r_swz) : $unsigned(r_swz);
    assign q_mag      = i_div_rsp.quo[COORD_W-1:0];
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Memory write and registered read.
    assign mem_we = (r_state == ST_IDLE) && i_cmd_valid && (i_cmd.code == CMD_LOAD) &&
                    (r_count != CNT_W'(TABLE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[ADDR_W-1:0]] <= {i_cmd.pos_x, i_cmd.pos_y, i_cmd.height};
        end
        r_rd_data <= r_mem[r_scan_idx[ADDR_W-1:0]];
    end

    // Distance pipeline: differences, squares, then one root bit per stage.
    assign sqx    = r_dx * r_dx;
    assign sqy    = r_dy * r_dy;
    assign sq_sum = {1'b0, r_sx} + {1'b0, r_sy};

    always_comb begin
        logic [REM_W-1:0] rem_t;
        logic [REM_W-1:0] trial;
        logic             ge;
        n_sq_rem[0]  = '0;
        n_sq_root[0] = '0;
        n_sq_rad[0]  = {sq_sum, {FRAC_W{1'b0}}};
        for (int s = 0; s < SQRT_STAGES; s++) begin
            rem_t = {r_sq_rem[s][REM_W-3:0], r_sq_rad[s][RAD_W-1 -: 2]};
            trial = REM_W'({r_sq_root[s], 2'b01});
            ge    = (rem_t >= trial);
            n_sq_rem[s+1]  = ge ? (rem_t - trial) : rem_t;
            n_sq_root[s+1] = {r_sq_root[s][DIST_W-2:0], ge};
            n_sq_rad[s+1]  = {r_sq_rad[s][RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx  <= {r_qx[COORD_W-1], r_qx} -
                 {r_rd_data[3*COORD_W-1], r_rd_data[3*COORD_W-1 -: COORD_W]};
        r_dy  <= {r_qy[COORD_W-1], r_qy} -
                 {r_rd_data[2*COORD_W-1], r_rd_data[2*COORD_W-1 -: COORD_W]};
        r_b_z <= r_rd_data[COORD_W-1:0];
        r_sx  <= sqx[SQ_W-2:0];
        r_sy  <= sqy[SQ_W-2:0];
        r_c_z <= r_b_z;
        r_sq_z[0] <= r_c_z;
        for (int s = 0; s <= SQRT_STAGES; s++) begin
            r_sq_rem[s]  <= n_sq_rem[s];
            r_sq_root[s] <= n_sq_root[s];
            r_sq_rad[s]  <= n_sq_rad[s];
        end
        for (int s = 1; s <= SQRT_STAGES; s++) begin
            r_sq_z[s] <= r_sq_z[s-1];
        end
    end

    // Sorted insertion: equal distances keep the earlier point ahead.
    always_comb begin
        for (int j = 0; j < MAX_NEIGHBORS; j++) begin
            le[j] = (NB_CNT_W'(j) < r_nb_n) && (r_nb_d[j] <= cand_d);
        end
        ins_p     = NB_CNT_W'($countones(le));
        nb_accept = r_sq_v[SQRT_STAGES] &&
                    (cand_d <= {{(DIST_W-RADIUS_W){1'b0}}, i_radius}) && (ins_p < k_eff);
        ins_n     = (r_nb_n < k_eff) ? (r_nb_n + NB_CNT_W'(1)) : r_nb_n;
        for (int j = 0; j < MAX_NEIGHBORS; j++) begin
            if (NB_CNT_W'(j) < ins_p) begin
                ins_d[j] = r_nb_d[j];
                ins_z[j] = r_nb_z[j];
            end else if (NB_CNT_W'(j) == ins_p) begin
                ins_d[j] = cand_d;
                ins_z[j] = r_sq_z[SQRT_STAGES];
            end else begin
                ins_d[j] = r_nb_d[(j == 0) ? 0 : j - 1];
                ins_z[j] = r_nb_z[(j == 0) ? 0 : j - 1];
            end
        end
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_scan_idx  = r_scan_idx;
        n_nb_n      = r_nb_n;
        n_wj        = r_wj;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        n_res       = r_res;
        n_qx        = r_qx;
        n_qy        = r_qy;
        n_w         = r_w;
        n_cur_z     = r_cur_z;
        n_prod      = r_prod;
        n_swz       = r_swz;
        n_sw        = r_sw;
        n_nb_d      = r_nb_d;
        n_nb_z      = r_nb_z;
        n_rd_v      = 1'b0;
        o_cmd_pop   = 1'b0;
        o_div_req   = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_res     = '0;
                    n_state   = ST_DONE;
                    case (i_cmd.code)
                        CMD_LOAD: begin
                            if (r_count == CNT_W'(TABLE_DEPTH)) begin
                                n_res.table_full = 1'b1;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_QUERY: begin
                            n_qx       = i_cmd.pos_x;
                            n_qy       = i_cmd.pos_y;
                            n_nb_n     = '0;
                            n_scan_idx = '0;
                            n_state    = ST_SCAN;
                        end
                        default: begin
                            n_res = '0;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (nb_accept) begin
                    n_nb_d = ins_d;
                    n_nb_z = ins_z;
                    n_nb_n = ins_n;
                end
                if (scan_issue) begin
                    n_rd_v     = 1'b1;
                    n_scan_idx = r_scan_idx + CNT_W'(1);
                end else if (!pipe_busy) begin
                    if (r_nb_n == '0) begin
                        n_res   = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_wj    = '0;
                        n_swz   = '0;
                        n_sw    = '0;
                        n_state = ST_WDIV;
                    end
                end
            end
            ST_WDIV: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = WEIGHT_NUM;
                o_div_req.den   = DEN_W'(r_nb_d[wj_idx]) + DEN_W'(1);
                n_cur_z         = r_nb_z[wj_idx];
                n_state         = ST_WWAIT;
            end
            ST_WWAIT: begin
                if (i_div_rsp.done) begin
                    n_w     = i_div_rsp.quo[W_W-1:0];
                    n_state = ST_WMUL;
                end
            end
            ST_WMUL: begin
                n_prod  = $signed({1'b0, r_w}) * r_cur_z;
                n_state = ST_WACC;
            end
            ST_WACC: begin
                n_swz = r_swz + {{(SWZ_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
                n_sw  = r_sw + DEN_W'(r_w);
                n_wj  = r_wj + NB_CNT_W'(1);
                if ((r_wj + NB_CNT_W'(1)) == r_nb_n) begin
                    n_state = ST_FDIV;
                end else begin
                    n_state = ST_WDIV;
                end
            end
            ST_FDIV: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = DIV_W'(swz_mag);
                o_div_req.den   = r_sw;
                n_state         = ST_FWAIT;
            end
            ST_FWAIT: begin
                if (i_div_rsp.done) begin
                    n_res.found      = 1'b1;
                    n_res.table_full = 1'b0;
                    n_res.height_out = r_swz[SWZ_W-1] ? (COORD_W'(0) - q_mag) : q_mag;
                    n_state          = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_item  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_scan_idx  <= '0;
            r_nb_n      <= '0;
            r_wj        <= '0;
            r_out_valid <= 1'b0;
            r_rd_v      <= 1'b0;
            r_b_v       <= 1'b0;
            r_c_v       <= 1'b0;
            r_sq_v      <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scan_idx  <= n_scan_idx;
            r_nb_n      <= n_nb_n;
            r_wj        <= n_wj;
            r_out_valid <= n_out_valid;
            r_rd_v      <= n_rd_v;
            r_b_v       <= r_rd_v;
            r_c_v       <= r_b_v;
            r_sq_v      <= {r_sq_v[SQRT_STAGES-1:0], r_c_v};
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        r_res      <= n_res;
        r_qx       <= n_qx;
        r_qy       <= n_qy;
        r_w        <= n_w;
        r_cur_z    <= n_cur_z;
        r_prod     <= n_prod;
        r_swz      <= n_swz;
        r_sw       <= n_sw;
        r_nb_d     <= n_nb_d;
        r_nb_z     <= n_nb_z;
    end

    `KNN_ASSERT(a_nb_within_k, ((r_state == ST_SCAN) |-> (r_nb_n <= k_eff)), "neighbor list longer than k")
    `KNN_ASSERT(a_nb_sorted, ((r_nb_n >= NB_CNT_W'(2)) |-> (r_nb_d[0] <= r_nb_d[1])), "neighbor list out of order")

endmodule

`default_nettype wire

[rtl/knn_inverse_distance_interpolator_unit.sv]
// Load, clear and unused items go from the queue through the DONE state to the output register.
// Query: the N stored points are scanned through the distance pipeline (one memory read per
// cycle), then the weight of each kept neighbor and the final quotient are computed,
// both on one shared 64-step divider. One item is worked on at a time behind a 4-deep queue.
// Reset is synchronous, active low: it empties the table and the queue and sets the
// registers to radius 0 and k 1; the point memory is not cleared.
`default_nettype none

module knn_inverse_distance_interpolator_unit import knn_idw_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_item,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [RADIUS_W-1:0] r_radius;
    logic [LIMIT_W-1:0]  r_limit;
    logic                cfg_we;
    logic                cmd_valid;
    t_cmd                cmd;
    logic                cmd_pop;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_LIMIT) ? {{(32-LIMIT_W){1'b0}}, r_limit} :
                                              {{(32-RADIUS_W){1'b0}}, r_radius};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            r_limit  <= LIMIT_W'(1);
        end else if (cfg_we) begin
            if (paddr[2] == REG_RADIUS) begin
                r_radius <= pwdata[RADIUS_W-1:0];
            end else begin
                r_limit <= pwdata[LIMIT_W-1:0];
            end
        end
    end

    knn_idw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    knn_idw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    knn_idw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_radius    (r_radius),
        .i_limit     (r_limit),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire
